[rtl/egbs_pkg.sv]
package egbs_pkg;

	localparam int MAX_COLS = 256;
	localparam int MAX_ROWS = 256;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int SIZE_W = 9;
	localparam int BANK_DEPTH = (MAX_COLS / 2) * (MAX_ROWS / 2);
	localparam int BANK_AW = $clog2(BANK_DEPTH);
	localparam int CELL_W = 17;

	localparam logic [1:0] ST_WRITTEN = 2'd0;
	localparam logic [1:0] ST_INTERP = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;
	localparam logic [1:0] ST_SEAM = 2'd3;

	localparam logic REQ_WRITE = 1'b0;

	localparam logic [2:0] REG_COLS = 3'd0;
	localparam logic [2:0] REG_ROWS = 3'd1;
	localparam logic [2:0] REG_ORG_X = 3'd2;
	localparam logic [2:0] REG_ORG_Z = 3'd3;
	localparam logic [2:0] REG_INV_X = 3'd4;
	localparam logic [2:0] REG_INV_Z = 3'd5;

	typedef struct packed {
		logic [0:0] req_type;
		logic [7:0] row_index;
		logic [7:0] col_index;
		logic signed [15:0] elevation;
		logic signed [31:0] query_x;
		logic signed [31:0] query_z;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [23:0] value;
		logic [3:0] corner_mask;
		logic signed [15:0] corner_ul;
		logic signed [15:0] corner_ur;
		logic signed [15:0] corner_ll;
		logic signed [15:0] corner_lr;
		logic [7:0] frac_x;
		logic [7:0] frac_z;
	} rsp_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CLEAR = 7'b0000010,
		S_MUL = 7'b0000100,
		S_FLOOR = 7'b0001000,
		S_READ = 7'b0010000,
		S_BLEND = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

endpackage

[rtl/egbs_if.sv]
interface egbs_req_if;
	logic valid;
	logic ready;
	egbs_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface egbs_rsp_if;
	logic valid;
	logic ready;
	egbs_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/egbs_ram.sv]
module egbs_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16384
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/elevation_grid_bilinear_sampler.sv]
// Elevation grid sampler. Writes store one elevation per cell; queries map a
// world point to grid coordinates and return a bilinear blend, a seam report
// with the corners present, or outside. The grid lies in four parity banks
// (row parity, column parity) so one read fetches all four corners at once.
// After reset the block sweeps every bank row clearing valid bits before
// the first item is accepted; configuration writes are taken throughout.
// Items run one at a time: a write passes through the multiply and output
// steps to its result beat, a query through multiply, floor, bank read,
// blend and output. A new item is accepted while the previous result beat
// still waits; a finished item holds in its output step only while that
// beat has not been taken.
module elevation_grid_bilinear_sampler (
	input logic clk,
	input logic arst_n,
	egbs_req_if.sink req,
	egbs_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int AW = egbs_pkg::BANK_AW;
	localparam int RH = egbs_pkg::ROW_W - 1;
	localparam int CH = egbs_pkg::COL_W - 1;

	// configuration registers
	logic [8:0] cols_q, rows_q;
	logic signed [31:0] org_x_q, org_z_q;
	logic [23:0] inv_x_q, inv_z_q;
	logic [2:0] reg_idx;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 9'd256;
			rows_q <= 9'd256;
			org_x_q <= '0;
			org_z_q <= '0;
			inv_x_q <= 24'd65536;
			inv_z_q <= 24'd65536;
		end else if (wr_en) begin
			case (reg_idx)
				egbs_pkg::REG_COLS: cols_q <= pwdata[8:0];
				egbs_pkg::REG_ROWS: rows_q <= pwdata[8:0];
				egbs_pkg::REG_ORG_X: org_x_q <= pwdata;
				egbs_pkg::REG_ORG_Z: org_z_q <= pwdata;
				egbs_pkg::REG_INV_X: inv_x_q <= pwdata[23:0];
				egbs_pkg::REG_INV_Z: inv_z_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			egbs_pkg::REG_COLS: prdata = {23'd0, cols_q};
			egbs_pkg::REG_ROWS: prdata = {23'd0, rows_q};
			egbs_pkg::REG_ORG_X: prdata = org_x_q;
			egbs_pkg::REG_ORG_Z: prdata = org_z_q;
			egbs_pkg::REG_INV_X: prdata = {8'd0, inv_x_q};
			egbs_pkg::REG_INV_Z: prdata = {8'd0, inv_z_q};
			default: prdata = '0;
		endcase
	end

	// effective sizes, saturated into 1..MAX
	logic [8:0] cols_eff, rows_eff;
	always_comb begin
		cols_eff = (cols_q == 9'd0) ? 9'd1 : cols_q;
		if (cols_eff > 9'(egbs_pkg::MAX_COLS)) cols_eff = 9'(egbs_pkg::MAX_COLS);
		rows_eff = (rows_q == 9'd0) ? 9'd1 : rows_q;
		if (rows_eff > 9'(egbs_pkg::MAX_ROWS)) rows_eff = 9'(egbs_pkg::MAX_ROWS);
	end

	egbs_pkg::state_t state_q;
	egbs_pkg::req_t req_q;
	logic [AW:0] clr_q;
	logic out_v_q;
	egbs_pkg::rsp_t out_q;
	logic out_go;

	assign req.ready = (state_q == egbs_pkg::S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.payload = out_q;
	// load the result register once the previous beat has gone
	assign out_go = (state_q == egbs_pkg::S_OUT) && (!out_v_q || rsp.ready);

	// stage 1: coordinate products
	logic signed [32:0] dx, dz;
	logic signed [57:0] cx_s1, cz_s1;
	logic wr_ok_s1;
	assign dx = 33'(req_q.query_x) - 33'(org_x_q);
	assign dz = 33'(req_q.query_z) - 33'(org_z_q);

	// stage 2: floor, range test, corner addresses
	logic signed [58:0] cy;
	logic signed [34:0] ix, iz;
	assign cy = (59'(rows_eff) - 59'sd1) * 59'sd16777216 - 59'(cz_s1);
	assign ix = 35'(cx_s1 >>> 24);
	assign iz = 35'(cy >>> 24);

	logic out_range;
	assign out_range = (ix < -35'sd1) || (iz < -35'sd1) ||
		(ix >= $signed(35'(cols_eff))) || (iz >= $signed(35'(rows_eff)));

	logic [7:0] fx_s2, fz_s2;
	logic signed [9:0] ix_s2, iz_s2;
	logic outside_s2;

	// bank addressing: bank b = {row parity, col parity}
	logic signed [10:0] r_of [4];
	logic signed [10:0] c_of [4];
	logic [3:0] inb;
	logic [AW-1:0] raddr [4];
	logic [AW-1:0] waddr;
	logic [3:0] bwe;
	logic [egbs_pkg::CELL_W-1:0] wdata;
	logic [egbs_pkg::CELL_W-1:0] rdata [4];
	logic [3:0] inb_s3;
	logic [1:0] par_s3;

	// corner k: 0 UL (iz,ix), 1 UR (iz,ix+1), 2 LL (iz+1,ix), 3 LR (iz+1,ix+1)
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			r_of[k] = 11'(iz_s2) + 11'(k / 2);
			c_of[k] = 11'(ix_s2) + 11'(k % 2);
			inb[k] = (r_of[k] >= 0) && (c_of[k] >= 0) &&
				(r_of[k] < 11'(rows_eff)) && (c_of[k] < 11'(cols_eff));
		end
		// bank of a cell with row r, col c is {r[0], c[0]}; its address {r>>1, c>>1}
		for (int b = 0; b < 4; b++) begin
			raddr[b] = '0;
			for (int k = 0; k < 4; k++) begin
				if ({r_of[k][0], c_of[k][0]} == 2'(b)) begin
					raddr[b] = {r_of[k][RH:1], c_of[k][CH:1]};
				end
			end
		end
	end

	always_comb begin
		bwe = '0;
		waddr = {req_q.row_index[RH:1], req_q.col_index[CH:1]};
		wdata = {1'b1, req_q.elevation};
		if (state_q == egbs_pkg::S_CLEAR) begin
			bwe = 4'hF;
			waddr = clr_q[AW-1:0];
			wdata = '0;
		end else if (state_q == egbs_pkg::S_MUL && req_q.req_type == egbs_pkg::REQ_WRITE &&
			{1'b0, req_q.row_index} < rows_eff && {1'b0, req_q.col_index} < cols_eff) begin
			bwe[{req_q.row_index[0], req_q.col_index[0]}] = 1'b1;
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		egbs_ram #(.WIDTH(egbs_pkg::CELL_W), .DEPTH(egbs_pkg::BANK_DEPTH)) u_bank (
			.clk(clk), .we(bwe[b]), .waddr(waddr), .wdata(wdata),
			.raddr(raddr[b]), .rdata(rdata[b])
		);
	end

	// stage 3: gather corners, form blend weights
	logic [3:0] mask;
	logic signed [15:0] cv [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			// corner k sits in bank par ^ {k/2, k%2}
			mask[k] = inb_s3[k] && rdata[2'(k) ^ par_s3][16];
			cv[k] = mask[k] ? rdata[2'(k) ^ par_s3][15:0] : 16'sd0;
		end
	end

	logic signed [15:0] cv_s4 [4];
	logic [3:0] mask_s4;
	logic signed [33:0] prod_s4 [4];
	logic [16:0] w [4];
	always_comb begin
		w[0] = 17'((9'd256 - 9'(fz_s2)) * (9'd256 - 9'(fx_s2)));
		w[1] = 17'((9'd256 - 9'(fz_s2)) * 9'(fx_s2));
		w[2] = 17'(9'(fz_s2) * (9'd256 - 9'(fx_s2)));
		w[3] = 17'(9'(fz_s2) * 9'(fx_s2));
	end

	logic signed [35:0] sum;
	assign sum = 36'(prod_s4[0]) + 36'(prod_s4[1]) + 36'(prod_s4[2]) +
		36'(prod_s4[3]) + 36'sd128;

	// result beat for the item in hand
	egbs_pkg::rsp_t res_d;
	always_comb begin
		res_d = '0;
		if (req_q.req_type == egbs_pkg::REQ_WRITE) begin
			res_d.status = wr_ok_s1 ? egbs_pkg::ST_WRITTEN : egbs_pkg::ST_OUTSIDE;
		end else if (outside_s2 || mask_s4 == 4'd0) begin
			res_d.status = egbs_pkg::ST_OUTSIDE;
		end else begin
			res_d.status = (mask_s4 == 4'hF) ? egbs_pkg::ST_INTERP : egbs_pkg::ST_SEAM;
			res_d.value = (mask_s4 == 4'hF) ? sum[31:8] : 24'sd0;
			res_d.corner_mask = mask_s4;
			res_d.corner_ul = cv_s4[0];
			res_d.corner_ur = cv_s4[1];
			res_d.corner_ll = cv_s4[2];
			res_d.corner_lr = cv_s4[3];
			res_d.frac_x = fx_s2;
			res_d.frac_z = fz_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == egbs_pkg::S_MUL) begin
			cx_s1 <= 58'(dx) * $signed({34'd0, inv_x_q});
			cz_s1 <= 58'(dz) * $signed({34'd0, inv_z_q});
			wr_ok_s1 <= (bwe != 4'd0);
		end
		if (state_q == egbs_pkg::S_FLOOR) begin
			fx_s2 <= cx_s1[23:16];
			fz_s2 <= cy[23:16];
			ix_s2 <= 10'(ix);
			iz_s2 <= 10'(iz);
			outside_s2 <= out_range;
		end
		if (state_q == egbs_pkg::S_READ) begin
			inb_s3 <= inb;
			par_s3 <= {iz_s2[0], ix_s2[0]};
		end
		if (state_q == egbs_pkg::S_BLEND) begin
			for (int k = 0; k < 4; k++) begin
				cv_s4[k] <= cv[k];
				prod_s4[k] <= 34'(cv[k]) * $signed({17'd0, w[k]});
			end
			mask_s4 <= mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egbs_pkg::S_CLEAR;
			clr_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_go) begin
				out_v_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				egbs_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(egbs_pkg::BANK_DEPTH - 1)) begin
						state_q <= egbs_pkg::S_IDLE;
					end
				end
				egbs_pkg::S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.payload;
						state_q <= egbs_pkg::S_MUL;
					end
				end
				egbs_pkg::S_MUL: begin
					// a write lands this cycle; the output step then reports it
					if (req_q.req_type == egbs_pkg::REQ_WRITE) begin
						state_q <= egbs_pkg::S_OUT;
					end else begin
						state_q <= egbs_pkg::S_FLOOR;
					end
				end
				egbs_pkg::S_FLOOR: state_q <= egbs_pkg::S_READ;
				egbs_pkg::S_READ: state_q <= egbs_pkg::S_BLEND;
				egbs_pkg::S_BLEND: state_q <= egbs_pkg::S_OUT;
				egbs_pkg::S_OUT: begin
					// hold until the result register is free
					if (out_go) begin
						out_q <= res_d;
						state_q <= egbs_pkg::S_IDLE;
					end
				end
				default: state_q <= egbs_pkg::S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == egbs_pkg::S_MUL))
		else $error("accept did not start an item");
	a_out_one_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == egbs_pkg::S_OUT) |=> out_v_q)
		else $error("result beat missing");
	a_value_only_interp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.status != egbs_pkg::ST_INTERP) |-> (out_q.value == 24'sd0))
		else $error("value set outside interpolation");
`endif
endmodule
